// ===== rtl/sfr_pkg.sv =====
`default_nettype none

package sfr_pkg;

   // Control bits that travel down the pipeline next to each word
   typedef struct packed {
      logic valid;   // stage holds a live word
      logic bypass;  // result is already known (equal bounds or sample in range)
      logic below;   // sample lay below the lower bound
      logic qodd;    // last quotient bit produced so far (parity after final step)
   } sfr_ctl_type;

   localparam sfr_ctl_type SFR_CTL_IDLE = '{valid: 1'b0, bypass: 1'b0, below: 1'b0,
                                            qodd: 1'b0};

endpackage : sfr_pkg

`default_nettype wire

// ===== rtl/sfr_prep.sv =====
`default_nettype none

// Front stage: bias to unsigned order, sort bounds, classify, form distance and width.
module sfr_prep
   import sfr_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    adv,
   input  wire logic                    in_valid,
   input  wire logic [SAMPLE_WIDTH-1:0] sample,
   input  wire logic [SAMPLE_WIDTH-1:0] low_bound,
   input  wire logic [SAMPLE_WIDTH-1:0] high_bound,
   output sfr_ctl_type                  ctl_ff,
   output logic [SAMPLE_WIDTH-1:0]      lo_ff,
   output logic [SAMPLE_WIDTH-1:0]      hi_ff,
   output logic [SAMPLE_WIDTH-1:0]      wid_ff,
   output logic [SAMPLE_WIDTH-1:0]      dist_ff
);

   localparam logic [SAMPLE_WIDTH-1:0] SIGN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   logic [SAMPLE_WIDTH-1:0] x, a, b, lo, hi;
   logic                    in_range, eq, below;
   sfr_ctl_type             ctl_in;
   logic [SAMPLE_WIDTH-1:0] lo_in, wid_in, dist_in;

   always_comb begin
      x        = sample ^ SIGN;
      a        = low_bound ^ SIGN;
      b        = high_bound ^ SIGN;
      lo       = (a > b) ? b : a;
      hi       = (a > b) ? a : b;
      eq       = (lo == hi);
      in_range = (x >= lo) && (x <= hi);
      below    = (x < lo);

      ctl_in.valid  = in_valid;
      ctl_in.bypass = eq || in_range;
      ctl_in.below  = below;
      ctl_in.qodd   = 1'b0;

      // bypass words carry their answer in the lo slot
      lo_in   = in_range ? x : lo;
      wid_in  = hi - lo;
      dist_in = below ? (lo - x) : (x - hi);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= SFR_CTL_IDLE;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi;
         wid_ff  <= wid_in;
         dist_ff <= dist_in;
      end
   end

endmodule : sfr_prep

`default_nettype wire

// ===== rtl/sfr_div_stage.sv =====
`default_nettype none

// One restoring-division step: brings in one dividend bit, one compare/subtract.
module sfr_div_stage
   import sfr_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    adv,
   input  wire sfr_ctl_type             ctl_i,
   input  wire logic [SAMPLE_WIDTH-1:0] lo_i,
   input  wire logic [SAMPLE_WIDTH-1:0] hi_i,
   input  wire logic [SAMPLE_WIDTH-1:0] wid_i,
   input  wire logic [SAMPLE_WIDTH-1:0] num_i,
   input  wire logic [SAMPLE_WIDTH-1:0] rem_i,
   output sfr_ctl_type                  ctl_ff,
   output logic [SAMPLE_WIDTH-1:0]      lo_ff,
   output logic [SAMPLE_WIDTH-1:0]      hi_ff,
   output logic [SAMPLE_WIDTH-1:0]      wid_ff,
   output logic [SAMPLE_WIDTH-1:0]      num_ff,
   output logic [SAMPLE_WIDTH-1:0]      rem_ff
);

   logic [SAMPLE_WIDTH:0]   trial, diff;
   logic                    ge;
   sfr_ctl_type             ctl_in;
   logic [SAMPLE_WIDTH-1:0] rem_in, num_in;

   always_comb begin
      trial  = {rem_i, num_i[SAMPLE_WIDTH-1]};
      diff   = trial - {1'b0, wid_i};
      ge     = (trial >= {1'b0, wid_i});
      rem_in = ge ? diff[SAMPLE_WIDTH-1:0] : trial[SAMPLE_WIDTH-1:0];
      num_in = {num_i[SAMPLE_WIDTH-2:0], 1'b0};
      ctl_in      = ctl_i;
      ctl_in.qodd = ge;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= SFR_CTL_IDLE;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_ff  <= lo_i;
         hi_ff  <= hi_i;
         wid_ff <= wid_i;
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

endmodule : sfr_div_stage

`default_nettype wire

// ===== rtl/signal_fold_into_range_core.sv =====
`default_nettype none

// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------------
// req      | in        | req_valid / req_stall  | req_sample, req_low_bound, req_high_bound
// rsp      | out       | rsp_valid / rsp_stall  | rsp_folded
//
// Throughput: one word per cycle while rsp_stall is low.
// Pipeline: prep stage, one stage per quotient bit of the restoring divider, and
//   output register.
// Reset (synchronous, active high) clears only the stage control words and the output valid bit.
// rsp_stall with a word waiting freezes the whole pipeline in the same cycle and
//   is reflected on req_stall; nothing is dropped or duplicated.
module signal_fold_into_range_core
   import sfr_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [SAMPLE_WIDTH-1:0] req_sample,
   input  wire logic [SAMPLE_WIDTH-1:0] req_low_bound,
   input  wire logic [SAMPLE_WIDTH-1:0] req_high_bound,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [SAMPLE_WIDTH-1:0]      rsp_folded
);

   localparam logic [SAMPLE_WIDTH-1:0] SIGN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // Whole pipeline moves together; it holds only while a finished word is refused.
   logic adv;

   // Stage buses: index 0 is the prep register, index k the k-th divider step.
   sfr_ctl_type             ctl_s [0:SAMPLE_WIDTH];
   logic [SAMPLE_WIDTH-1:0] lo_s  [0:SAMPLE_WIDTH];
   logic [SAMPLE_WIDTH-1:0] hi_s  [0:SAMPLE_WIDTH];
   logic [SAMPLE_WIDTH-1:0] wid_s [0:SAMPLE_WIDTH];
   logic [SAMPLE_WIDTH-1:0] num_s [0:SAMPLE_WIDTH];
   logic [SAMPLE_WIDTH-1:0] rem_s [0:SAMPLE_WIDTH];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] rsp_folded_ff, rsp_folded_in;
   logic [SAMPLE_WIDTH-1:0] fold_biased;
   sfr_ctl_type             last;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rem_s[0]  = '0;

   sfr_prep #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (req_valid),
      .sample     (req_sample),
      .low_bound  (req_low_bound),
      .high_bound (req_high_bound),
      .ctl_ff     (ctl_s[0]),
      .lo_ff      (lo_s[0]),
      .hi_ff      (hi_s[0]),
      .wid_ff     (wid_s[0]),
      .dist_ff    (num_s[0])
   );

   // Dividend bits enter MSB first; after the last step rem is the remainder and
   // qodd the quotient LSB.
   for (genvar k = 0; k < SAMPLE_WIDTH; k++) begin : g_div
      sfr_div_stage #(
         .SAMPLE_WIDTH(SAMPLE_WIDTH)
      ) u_step (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .ctl_i  (ctl_s[k]),
         .lo_i   (lo_s[k]),
         .hi_i   (hi_s[k]),
         .wid_i  (wid_s[k]),
         .num_i  (num_s[k]),
         .rem_i  (rem_s[k]),
         .ctl_ff (ctl_s[k+1]),
         .lo_ff  (lo_s[k+1]),
         .hi_ff  (hi_s[k+1]),
         .wid_ff (wid_s[k+1]),
         .num_ff (num_s[k+1]),
         .rem_ff (rem_s[k+1])
      );
   end

   // Reflection: bypass words take the lo slot; otherwise count up from min when side and
   // parity disagree (below/even, above/odd), else count down from max.
   always_comb begin
      last = ctl_s[SAMPLE_WIDTH];
      if (last.bypass) begin
         fold_biased = lo_s[SAMPLE_WIDTH];
      end else if (last.below ^ last.qodd) begin
         fold_biased = lo_s[SAMPLE_WIDTH] + rem_s[SAMPLE_WIDTH];
      end else begin
         fold_biased = hi_s[SAMPLE_WIDTH] - rem_s[SAMPLE_WIDTH];
      end
      rsp_valid_in  = last.valid;
      rsp_folded_in = fold_biased ^ SIGN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_folded_ff <= rsp_folded_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_folded = rsp_folded_ff;

endmodule : signal_fold_into_range_core

`default_nettype wire

// ===== rtl/sfr_checker.sv =====
`default_nettype none

module sfr_checker #(
   parameter int SAMPLE_WIDTH = 32
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_stall,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire logic [SAMPLE_WIDTH-1:0] rsp_folded
);

   // reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // input side holds exactly when a finished word is refused
   a_stall_link : assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not follow output backpressure");

   // refused word stays put
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_folded))
      else $error("stalled result word changed");

   // an empty output register never holds back the input
   a_no_idle_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output register");

endmodule : sfr_checker

bind signal_fold_into_range_core sfr_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_sfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_folded (rsp_folded)
);

`default_nettype wire

// ===== tb/signal_fold_into_range_core_test.sv =====
`timescale 1ns / 1ps

module signal_fold_into_range_core_test;

   localparam int W       = 32;
   localparam int LATENCY = W + 2;                        // prep + divider stages + output reg
   localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] WMIN = SIGN;                  // most negative word
   localparam logic [W-1:0] WMAX = ~SIGN;                 // most positive word
   localparam int ONE = 1 << 16;                          // 1.0 in Q16.16

   typedef logic [W-1:0] word_type;

   // one pending request word plus how the sender treats it
   typedef struct {
      word_type    sample;
      word_type    lo;
      word_type    hi;
      int unsigned gap;     // idle cycles before presenting it
      bit          drain;   // hold it back until every folded word is back
   } fold_req_type;

   logic     clock          = 1'b0;
   logic     reset          = 1'b1;
   logic     req_valid      = 1'b0;
   logic     req_stall;
   word_type req_sample     = '0;
   word_type req_low_bound  = '0;
   word_type req_high_bound = '0;
   logic     rsp_valid;
   logic     rsp_stall      = 1'b0;
   word_type rsp_folded;

   fold_req_type pending_q[$];     // words still to send
   word_type     folded_due[$];    // predicted folded words, oldest first
   int unsigned  words_sent   = 0;
   int unsigned  words_folded = 0;
   int unsigned  err_cnt      = 0;
   int unsigned  idle_cnt     = 0;
   int unsigned  stall_left   = 0;
   bit           recv_calm    = 1'b0;

   signal_fold_into_range_core #(.SAMPLE_WIDTH(W)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_low_bound  (req_low_bound),
      .req_high_bound (req_high_bound),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_folded     (rsp_folded)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Fold prediction. Flipping the sign bit maps two's complement onto an
   // order-preserving unsigned scale, so widths and distances up to 2^W - 1
   // stay exact in plain W-bit unsigned math.
   function automatic word_type reflect_into_range(word_type s, word_type a, word_type b);
      word_type x, lo, hi, w, d, q, r;
      x  = s ^ SIGN;
      lo = a ^ SIGN;
      hi = b ^ SIGN;
      if (lo > hi) begin
         w  = lo;
         lo = hi;
         hi = w;
      end
      if (lo == hi) return lo ^ SIGN;
      if (x >= lo && x <= hi) return s;
      w = hi - lo;
      if (x < lo) begin
         d = lo - x;
         q = d / w;
         r = d % w;
         // even quotient counts up from min, odd comes back down from max
         return (q[0] ? hi - r : lo + r) ^ SIGN;
      end
      d = x - hi;
      q = d / w;
      r = d % w;
      return (q[0] ? lo + r : hi - r) ^ SIGN;
   endfunction

   task automatic queue_word(word_type s, word_type a, word_type b, int unsigned gap,
                             bit drain);
      fold_req_type item;
      item.sample = s;
      item.lo     = a;
      item.hi     = b;
      item.gap    = gap;
      item.drain  = drain;
      pending_q.push_back(item);
   endtask

   // Request driver: holds valid and payload until accepted, then waits the
   // next word's gap before presenting it. A drain word waits until the
   // count of folded words catches up with the count sent.
   always @(posedge clock) begin : drive_req
      bit           taken;
      bit           nxt_valid;
      int unsigned  sent_now;
      fold_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         idle_cnt  <= 0;
      end else begin
         taken     = req_valid && !req_stall;
         nxt_valid = req_valid && req_stall;
         sent_now  = words_sent + (taken ? 1 : 0);
         if (taken) begin
            folded_due.push_back(reflect_into_range(req_sample, req_low_bound,
                                                    req_high_bound));
            words_sent <= sent_now;
         end
         if (!nxt_valid && pending_q.size() != 0) begin
            if (idle_cnt < pending_q[0].gap) begin
               idle_cnt <= idle_cnt + 1;
            end else if (!(pending_q[0].drain && sent_now != words_folded)) begin
               nxt            = pending_q.pop_front();
               req_sample     <= nxt.sample;
               req_low_bound  <= nxt.lo;
               req_high_bound <= nxt.hi;
               nxt_valid      = 1'b1;
               idle_cnt       <= 0;
            end
         end
         req_valid <= nxt_valid;
      end
   end

   // Result monitor: checks each accepted word against the oldest prediction,
   // then draws how long to stall before taking the next one. Stalling runs
   // whether or not a word is waiting, so it lands on every pipeline phase.
   always @(posedge clock) begin : check_rsp
      word_type    want;
      int unsigned n;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (folded_due.size() == 0) begin
            err_cnt++;
            $display("%0t: unexpected word, expected none, actual rsp_folded %h",
                     $time, rsp_folded);
         end else begin
            want = folded_due.pop_front();
            if (rsp_folded !== want) begin
               err_cnt++;
               $display("%0t: rsp_folded mismatch, expected %h, actual %h",
                        $time, want, rsp_folded);
            end
         end
         words_folded <= words_folded + 1;
         // switch between stall-free stretches and random stalling now and then
         if (words_folded % 97 == 0) recv_calm <= ($urandom_range(0, 3) == 0);
         n = recv_calm ? 0 : $urandom_range(0, 3);
         stall_left <= n;
         rsp_stall  <= (n != 0);
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end
   end

   initial begin : stimulus
      word_type    s, a, b, t;
      int          lo_i, w_i, off;
      int unsigned kind, gap;
      bit          calm;

      // directed words: ordering of bounds, bypass cases, each fold direction
      queue_word(3 * ONE, ONE, ONE, 0, 0);                       // equal bounds
      queue_word(WMAX, WMIN, WMIN, 0, 0);                        // equal at extremes
      queue_word(WMIN, WMAX, WMAX, 0, 0);
      queue_word(ONE / 2, -ONE, ONE, 0, 0);                      // in range
      queue_word(-ONE, -ONE, ONE, 1, 0);                         // on lower bound
      queue_word(ONE, -ONE, ONE, 0, 0);                          // on upper bound
      queue_word(0, ONE, -ONE, 2, 0);                            // swapped, in range
      queue_word(-ONE - ONE / 4, -ONE, ONE, 0, 0);               // below, even quotient
      queue_word(-3 * ONE - ONE / 4, -ONE, ONE, 3, 0);           // below, odd quotient
      queue_word(ONE + ONE / 4, -ONE, ONE, 0, 0);                // above, even quotient
      queue_word(3 * ONE + ONE / 4, -ONE, ONE, 0, 0);            // above, odd quotient
      queue_word(-3 * ONE, -ONE, ONE, 1, 0);                     // below, zero remainder
      queue_word(5 * ONE, -ONE, ONE, 0, 0);                      // above, zero remainder
      queue_word(5 * ONE + 7, ONE, -ONE, 0, 0);                  // swapped, outside
      queue_word(WMIN, WMAX - 1, WMAX, 2, 0);                    // width 1, huge distance
      queue_word(WMAX, WMIN, WMIN + 1, 0, 0);
      queue_word(WMIN, WMIN, WMAX, 0, 0);                        // full range
      queue_word(WMAX, WMAX, WMIN, 0, 0);
      queue_word(WMAX, WMIN, WMAX - 1, 1, 0);                    // widest fold, above
      queue_word(WMIN, WMAX, WMIN + 1, 0, 0);                    // widest fold, below
      queue_word(WMAX, WMIN, WMIN, 3, 0);
      queue_word('0, '0, '0, 0, 0);
      queue_word('1, '1, 32'h0000_0001, 0, 0);

      // random words; a few drain points give the pipeline a full flush
      calm = 1'b0;
      for (int i = 0; i < 800; i++) begin
         if (i % 100 == 0) calm = ($urandom_range(0, 2) == 0);
         gap  = calm ? 0 : $urandom_range(0, 3);
         kind = $urandom_range(0, 9);
         case (kind)
            0: begin
               s = $urandom;
               a = $urandom;
               b = $urandom;
            end
            1: begin
               a = $urandom;
               b = a;
               s = $urandom;
            end
            8: begin
               // very narrow range anywhere: long division chains
               a = $urandom;
               b = a + word_type'($urandom_range(1, 2));
               s = $urandom;
            end
            9: begin
               // nearly full-scale range with samples near the rails
               a = WMIN + word_type'($urandom_range(0, 255));
               b = WMAX - word_type'($urandom_range(0, 255));
               case ($urandom_range(0, 2))
                  0:       s = WMIN + word_type'($urandom_range(0, 255));
                  1:       s = WMAX - word_type'($urandom_range(0, 255));
                  default: s = $urandom;
               endcase
            end
            default: begin
               // modest range near zero, sample a few widths out: many quotients,
               // remainders of zero and of a full width included
               w_i  = $urandom_range(1, 4 * ONE);
               lo_i = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
               off  = int'($urandom_range(0, 6)) * w_i + int'($urandom_range(0, w_i));
               a    = lo_i;
               b    = lo_i + w_i;
               case ($urandom_range(0, 2))
                  0:       s = lo_i - off;
                  1:       s = lo_i + w_i + off;
                  default: s = lo_i + int'($urandom_range(0, w_i));
               endcase
            end
         endcase
         if ($urandom_range(0, 1)) begin
            t = a;
            a = b;
            b = t;
         end
         queue_word(s, a, b, gap, (i % 250) == 125);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid || words_folded != words_sent)
         @(posedge clock);
      // let any stray word surface
      repeat (LATENCY + 8) @(posedge clock);

      if (err_cnt == 0 && folded_due.size() == 0) begin
         $display("signal_fold_into_range_core verification clean");
      end else begin
         $display("signal_fold_into_range_core verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("signal_fold_into_range_core verification failed");
      $finish;
   end

endmodule

// ===== signal_fold_into_range_core.f =====
rtl/sfr_pkg.sv
rtl/sfr_prep.sv
rtl/sfr_div_stage.sv
rtl/signal_fold_into_range_core.sv
rtl/sfr_checker.sv
tb/signal_fold_into_range_core_test.sv
